[hdl/uicf_pkg.sv]
// Shared types, constants and byte-class functions for the invisible character filter.
package uicf_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned SLOTS    = 3;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QAW      = $clog2(QDEPTH);
	localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'hFFFF;

	localparam logic [BYTE_W-1:0] B_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] B_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] B_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] B_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] B_DEL   = 8'h7F;
	localparam logic [BYTE_W-1:0] B_E2    = 8'hE2;
	localparam logic [BYTE_W-1:0] B_EF    = 8'hEF;
	localparam logic [BYTE_W-1:0] B_80    = 8'h80;
	localparam logic [BYTE_W-1:0] B_81    = 8'h81;
	localparam logic [BYTE_W-1:0] B_BB    = 8'hBB;
	localparam logic [BYTE_W-1:0] B_BF    = 8'hBF;
	localparam logic [BYTE_W-1:0] B_8B    = 8'h8B;
	localparam logic [BYTE_W-1:0] B_8F    = 8'h8F;
	localparam logic [BYTE_W-1:0] B_AA    = 8'hAA;
	localparam logic [BYTE_W-1:0] B_AE    = 8'hAE;
	localparam logic [BYTE_W-1:0] B_A6    = 8'hA6;
	localparam logic [BYTE_W-1:0] B_A9    = 8'hA9;

	// One input item after classification: up to three kept bytes, then maybe a close.
	typedef struct packed {
		logic [SLOTS-1:0][BYTE_W-1:0] bytes;
		logic [1:0]                   nbytes;
		logic                         eos;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} q_push_t;

	typedef struct packed {
		logic    empty;
		logic    full;
		bundle_t head;
	} q_stat_t;

	function automatic logic is_prefix(input logic [BYTE_W-1:0] b);
		return (b == B_E2) || (b == B_EF);
	endfunction

	function automatic logic is_kept(input logic [BYTE_W-1:0] b);
		return !(((b < B_SPACE) && (b != B_LF) && (b != B_TAB)) || (b == B_DEL));
	endfunction

	function automatic logic second_ok(input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] b);
		return ((h0 == B_E2) && ((b == B_80) || (b == B_81))) || ((h0 == B_EF) && (b == B_BB));
	endfunction

	function automatic logic third_ok(input logic [BYTE_W-1:0] h0, input logic [BYTE_W-1:0] h1,
	                                  input logic [BYTE_W-1:0] b);
		logic r;
		r = 1'b0;
		if ((h0 == B_E2) && (h1 == B_80))
			r = ((b >= B_8B) && (b <= B_8F)) || ((b >= B_AA) && (b <= B_AE));
		else if ((h0 == B_E2) && (h1 == B_81))
			r = (b >= B_A6) && (b <= B_A9);
		else
			r = (h0 == B_EF) && (h1 == B_BB) && (b == B_BF);
		return r;
	endfunction

endpackage

[hdl/uicf_if.sv]
// Channel interfaces: input bytes, result items and the length register write.
interface uicf_in_if;
	logic                          valid;
	logic                          ready;
	logic [uicf_pkg::BYTE_W-1:0]   in_byte;
	logic                          last;
	modport source (output valid, in_byte, last, input ready);
	modport sink   (input valid, in_byte, last, output ready);
endinterface

interface uicf_out_if;
	logic                          valid;
	logic                          ready;
	logic [uicf_pkg::BYTE_W-1:0]   out_byte;
	logic                          has_byte;
	logic                          end_of_string;
	logic [uicf_pkg::LEN_W-1:0]    written_length;
	modport source (output valid, out_byte, has_byte, end_of_string, written_length,
	                input ready);
	modport sink   (input valid, out_byte, has_byte, end_of_string, written_length,
	                output ready);
endinterface

interface uicf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [uicf_pkg::LEN_W-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[hdl/uicf_front.sv]
// Front end: prefix matching of the zero-width sequences and control-byte removal.
module uicf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	uicf_in_if.sink              item,
	input  uicf_pkg::q_stat_t    qstat,
	output uicf_pkg::q_push_t    push
);

	logic [1:0]                      hc_q, hc_d;
	logic [uicf_pkg::BYTE_W-1:0]     h0_q, h0_d, h1_q, h1_d;
	logic                            closed_q, closed_d;
	logic [1:0]                      n;
	logic [uicf_pkg::SLOTS-1:0][uicf_pkg::BYTE_W-1:0] bytes;
	logic [uicf_pkg::BYTE_W-1:0]     b;
	logic                            accept;

	assign item.ready = !qstat.full;
	assign accept     = item.valid && item.ready;
	assign b          = item.in_byte;

	always_comb begin
		n        = 2'd0;
		bytes    = '0;
		hc_d     = hc_q;
		h0_d     = h0_q;
		h1_d     = h1_q;
		closed_d = closed_q;
		if (!closed_q) begin
			if (b == uicf_pkg::B_NUL) begin
				// held prefix bytes are never control bytes
				if (hc_q != 2'd0) begin
					bytes[0] = h0_q;
					n        = 2'd1;
				end
				if (hc_q == 2'd2) begin
					bytes[1] = h1_q;
					n        = 2'd2;
				end
				hc_d     = 2'd0;
				closed_d = 1'b1;
			end else begin
				case (hc_q)
					2'd0: begin
						if (uicf_pkg::is_prefix(b)) begin
							h0_d = b;
							hc_d = 2'd1;
						end else if (uicf_pkg::is_kept(b)) begin
							bytes[0] = b;
							n        = 2'd1;
						end
					end
					2'd1: begin
						if (uicf_pkg::second_ok(h0_q, b)) begin
							h1_d = b;
							hc_d = 2'd2;
						end else begin
							bytes[0] = h0_q;
							n        = 2'd1;
							if (uicf_pkg::is_prefix(b)) begin
								h0_d = b;
								hc_d = 2'd1;
							end else begin
								hc_d = 2'd0;
								if (uicf_pkg::is_kept(b)) begin
									bytes[1] = b;
									n        = 2'd2;
								end
							end
						end
					end
					default: begin
						if (uicf_pkg::third_ok(h0_q, h1_q, b)) begin
							hc_d = 2'd0;
						end else begin
							// h1 is a continuation byte, so it never starts a new prefix
							bytes[0] = h0_q;
							bytes[1] = h1_q;
							n        = 2'd2;
							if (uicf_pkg::is_prefix(b)) begin
								h0_d = b;
								hc_d = 2'd1;
							end else begin
								hc_d = 2'd0;
								if (uicf_pkg::is_kept(b)) begin
									bytes[2] = b;
									n        = 2'd3;
								end
							end
						end
					end
				endcase
			end
		end
		if (item.last) begin
			// whatever is still held goes out before the close
			if (hc_d != 2'd0) begin
				bytes[n] = h0_d;
				n        = n + 2'd1;
			end
			if (hc_d == 2'd2) begin
				bytes[n] = h1_d;
				n        = n + 2'd1;
			end
			hc_d     = 2'd0;
			closed_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q     <= 2'd0;
			closed_q <= 1'b0;
		end else if (accept) begin
			hc_q     <= hc_d;
			closed_q <= closed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h0_q <= h0_d;
			h1_q <= h1_d;
		end
	end

	always_comb begin
		push             = '0;
		push.data.bytes  = bytes;
		push.data.nbytes = n;
		push.data.eos    = item.last;
		push.valid       = accept && ((n != 2'd0) || item.last);
	end

endmodule

[hdl/uicf_queue.sv]
// Four-entry queue of classified requests between front and back end.
module uicf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  uicf_pkg::q_push_t    push,
	input  logic                 pop,
	output uicf_pkg::q_stat_t    qstat
);

	uicf_pkg::bundle_t                 mem_q [uicf_pkg::QDEPTH];
	logic [uicf_pkg::QAW-1:0]          wp_q, rp_q;
	logic [uicf_pkg::QCNT_W-1:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push.valid && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push.valid && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wp_q] <= push.data;
	end

	always_comb begin
		qstat.empty = (cnt_q == '0);
		qstat.full  = (cnt_q == uicf_pkg::QCNT_W'(uicf_pkg::QDEPTH));
		qstat.head  = mem_q[rp_q];
	end

endmodule

[hdl/uicf_back.sv]
// Back end: length limit, per-string byte count and the result output register.
module uicf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  uicf_pkg::q_stat_t    qstat,
	output logic                 pop,
	uicf_out_if.source           res,
	uicf_cfg_if.sink             cfg
);

	logic [uicf_pkg::LEN_W-1:0]    max_q, cnt_q;
	logic [1:0]                    idx_q;
	logic                          valid_q, has_q, eos_q;
	logic [uicf_pkg::BYTE_W-1:0]   byte_q;
	logic [uicf_pkg::LEN_W-1:0]    len_q;
	logic [2:0]                    total;
	logic                          cur_is_byte, produce, out_free, step;
	logic [uicf_pkg::BYTE_W-1:0]   cur_byte;
	logic [uicf_pkg::LEN_W-1:0]    cnt_inc;

	assign cfg.ready   = 1'b1;

	assign total       = {1'b0, qstat.head.nbytes} + {2'b00, qstat.head.eos};
	assign cur_is_byte = idx_q < qstat.head.nbytes;
	assign cur_byte    = qstat.head.bytes[idx_q];
	assign cnt_inc     = cnt_q + 1'b1;
	// a byte past the limit still takes its slot but produces nothing
	assign produce     = cur_is_byte ? (cnt_q < max_q) : 1'b1;
	assign out_free    = !valid_q || res.ready;
	assign step        = !qstat.empty && (out_free || !produce);
	assign pop         = step && (({1'b0, idx_q} + 3'd1) == total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= uicf_pkg::MAX_LEN_RESET;
			cnt_q   <= '0;
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (cfg.valid)
				max_q <= cfg.data;
			if (step) begin
				idx_q <= pop ? 2'd0 : idx_q + 2'd1;
				if (!cur_is_byte)
					cnt_q <= '0;
				else if (produce)
					cnt_q <= cnt_inc;
			end
			if (out_free)
				valid_q <= step && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (step && produce && out_free) begin
			if (cur_is_byte) begin
				byte_q <= cur_byte;
				has_q  <= 1'b1;
				eos_q  <= 1'b0;
				len_q  <= cnt_inc;
			end else begin
				byte_q <= uicf_pkg::B_NUL;
				has_q  <= 1'b0;
				eos_q  <= 1'b1;
				len_q  <= cnt_q;
			end
		end
	end

	assign res.valid          = valid_q;
	assign res.out_byte       = byte_q;
	assign res.has_byte       = has_q;
	assign res.end_of_string  = eos_q;
	assign res.written_length = len_q;

endmodule

[hdl/utf8_invisible_char_filter_core.sv]
// Top level of the UTF-8 control and zero-width character stripper.
// Takes one source byte per cycle whenever the four-entry request queue has room;
// matching of the invisible three-byte sequences is done in that same cycle.
// The back end emits one result per cycle from a registered output stage while the
// receiver is ready. An input byte yields at most four results (kept bytes plus the
// closing item); a length-limited byte takes a back-end step without a result, and
// one dropped or held as a prefix takes no step. Sustained rate is one byte per
// cycle for ordinary text with a ready receiver; flush bursts are absorbed by the
// queue. The user must see that max_length is written through cfg while no request
// is in flight; the block has no check. It applies to later bytes, also mid-string.
module utf8_invisible_char_filter_core (
	input  logic         clk,
	input  logic         arst_n,
	uicf_in_if.sink      item,
	uicf_out_if.source   res,
	uicf_cfg_if.sink     cfg
);

	uicf_pkg::q_push_t push;
	uicf_pkg::q_stat_t qstat;
	logic              pop;

	uicf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.qstat  (qstat),
		.push   (push)
	);

	uicf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat)
	);

	uicf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.pop    (pop),
		.res    (res),
		.cfg    (cfg)
	);

endmodule

[hdl/uicf_checker.sv]
// Port-level checker for the filter top level, attached by bind.
module uicf_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic [uicf_pkg::BYTE_W-1:0]   res_out_byte,
	input  logic                          res_has_byte,
	input  logic                          res_end_of_string,
	input  logic [uicf_pkg::LEN_W-1:0]    res_written_length
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_out_byte)
		&& $stable(res_written_length) && $stable(res_end_of_string))
		else $error("result changed while stalled");

	// data items carry a nonzero running length and are never closing items
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_has_byte |-> !res_end_of_string && (res_written_length != '0))
		else $error("bad data item");

	// closing item carries no byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_has_byte |-> res_end_of_string && (res_out_byte == uicf_pkg::B_NUL))
		else $error("bad closing item");

	// stripped control bytes never reach the output
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_has_byte |-> uicf_pkg::is_kept(res_out_byte))
		else $error("control byte passed");

endmodule

bind utf8_invisible_char_filter_core uicf_checker u_uicf_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_out_byte       (res.out_byte),
	.res_has_byte       (res.has_byte),
	.res_end_of_string  (res.end_of_string),
	.res_written_length (res.written_length)
);

[test/tb.sv]
// Self-checking testbench for the UTF-8 control and zero-width character stripper.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [uicf_pkg::BYTE_W-1:0] b;
		logic                        last;
	} src_byte_t;

	typedef struct packed {
		logic [uicf_pkg::BYTE_W-1:0] ob;
		logic                        has;
		logic                        eos;
		logic [uicf_pkg::LEN_W-1:0]  len;
	} filt_result_t;

	logic clk;
	logic arst_n;

	uicf_in_if  in_ch ();
	uicf_out_if out_ch ();
	uicf_cfg_if cfg_ch ();

	utf8_invisible_char_filter_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.res    (out_ch),
		.cfg    (cfg_ch)
	);

	src_byte_t    pending_bytes[$];
	filt_result_t expected_results[$];

	// filter state as the block should hold it
	logic [uicf_pkg::LEN_W-1:0]  max_len_cfg = uicf_pkg::MAX_LEN_RESET;
	logic [uicf_pkg::BYTE_W-1:0] held [2] = '{8'h00, 8'h00};
	logic [1:0]                  held_n = 2'd0;
	logic [uicf_pkg::LEN_W-1:0]  str_len = '0;
	logic                        str_closed = 1'b0;

	int   err_count = 0;
	int   stim_pushed = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_reqs = 0;
	int   hold_done = 0;
	int   hold_left = 0;
	logic in_fire = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	function automatic void keep_byte(input logic [uicf_pkg::BYTE_W-1:0] b);
		if (((b < uicf_pkg::B_SPACE) && (b != uicf_pkg::B_LF) && (b != uicf_pkg::B_TAB))
		    || (b == uicf_pkg::B_DEL))
			return;
		if (str_len >= max_len_cfg)
			return;
		str_len = str_len + 1'b1;
		expected_results.push_back('{ob: b, has: 1'b1, eos: 1'b0, len: str_len});
	endfunction

	function automatic logic continues_prefix(input logic [uicf_pkg::BYTE_W-1:0] h0,
	                                          input logic [uicf_pkg::BYTE_W-1:0] b);
		if (h0 == uicf_pkg::B_E2)
			return (b == uicf_pkg::B_80) || (b == uicf_pkg::B_81);
		return (h0 == uicf_pkg::B_EF) && (b == uicf_pkg::B_BB);
	endfunction

	function automatic logic completes_seq(input logic [uicf_pkg::BYTE_W-1:0] h0,
	                                       input logic [uicf_pkg::BYTE_W-1:0] h1,
	                                       input logic [uicf_pkg::BYTE_W-1:0] b);
		if (h0 == uicf_pkg::B_E2 && h1 == uicf_pkg::B_80)
			return (b >= uicf_pkg::B_8B && b <= uicf_pkg::B_8F)
			    || (b >= uicf_pkg::B_AA && b <= uicf_pkg::B_AE);
		if (h0 == uicf_pkg::B_E2 && h1 == uicf_pkg::B_81)
			return b >= uicf_pkg::B_A6 && b <= uicf_pkg::B_A9;
		return h0 == uicf_pkg::B_EF && h1 == uicf_pkg::B_BB && b == uicf_pkg::B_BF;
	endfunction

	function automatic void flush_held();
		if (held_n >= 2'd1)
			keep_byte(held[0]);
		if (held_n >= 2'd2)
			keep_byte(held[1]);
		held_n = 2'd0;
	endfunction

	// a broken-off prefix writes its first byte and the rest is looked at again
	function automatic void absorb_byte(input logic [uicf_pkg::BYTE_W-1:0] b);
		logic done;
		done = 1'b0;
		while (!done) begin
			if (held_n == 2'd0) begin
				if (b == uicf_pkg::B_E2 || b == uicf_pkg::B_EF) begin
					held[0] = b;
					held_n = 2'd1;
				end else begin
					keep_byte(b);
				end
				done = 1'b1;
			end else if (held_n == 2'd1) begin
				if (continues_prefix(held[0], b)) begin
					held[1] = b;
					held_n = 2'd2;
					done = 1'b1;
				end else begin
					keep_byte(held[0]);
					held_n = 2'd0;
				end
			end else begin
				if (completes_seq(held[0], held[1], b)) begin
					held_n = 2'd0;
					done = 1'b1;
				end else begin
					keep_byte(held[0]);
					held[0] = held[1];
					held_n = 2'd1;
				end
			end
		end
	endfunction

	function automatic void predict_filter(input logic [uicf_pkg::BYTE_W-1:0] b,
	                                       input logic last);
		if (!str_closed) begin
			if (b == uicf_pkg::B_NUL) begin
				flush_held();
				str_closed = 1'b1;
			end else begin
				absorb_byte(b);
			end
		end
		if (last) begin
			flush_held();
			expected_results.push_back('{ob: 8'h00, has: 1'b0, eos: 1'b1, len: str_len});
			held[0] = 8'h00;
			held[1] = 8'h00;
			str_len = '0;
			str_closed = 1'b0;
		end
	endfunction

	// accepted requests feed the prediction; accepted results are checked
	always @(posedge clk) begin : check
		filt_result_t want;
		in_fire <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready)
			predict_filter(in_ch.in_byte, in_ch.last);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected, out_byte",
				                int'(out_ch.out_byte), 0);
			end else begin
				want = expected_results.pop_front();
				if (out_ch.out_byte !== want.ob)
					report_mismatch("out_byte", int'(out_ch.out_byte), int'(want.ob));
				if (out_ch.has_byte !== want.has)
					report_mismatch("has_byte", int'(out_ch.has_byte), int'(want.has));
				if (out_ch.end_of_string !== want.eos)
					report_mismatch("end_of_string", int'(out_ch.end_of_string),
					                int'(want.eos));
				if (out_ch.written_length !== want.len)
					report_mismatch("written_length", int'(out_ch.written_length),
					                int'(want.len));
			end
		end
	end

	always @(negedge clk) begin : drive
		src_byte_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_fire) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_bytes.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.in_byte <= nxt.b;
				in_ch.last <= nxt.last;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_done != hold_reqs) begin
			hold_done = hold_reqs;
			hold_left = 150;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic push_byte(input logic [uicf_pkg::BYTE_W-1:0] b, input logic last);
		pending_bytes.push_back('{b: b, last: last});
		stim_pushed++;
	endtask

	task automatic write_max_length(input logic [uicf_pkg::LEN_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		max_len_cfg = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending_bytes.size() != 0 || in_ch.valid);
		do @(negedge clk); while (expected_results.size() != 0);
		// length-limited drops keep the back end busy without a result
		repeat (24) @(negedge clk);
	endtask

	// random string: mostly text and invisible sequences, some broken ones and noise
	task automatic add_random_string();
		int n_tok;
		int kind;
		int sel;
		logic [uicf_pkg::BYTE_W-1:0] h0;
		logic [uicf_pkg::BYTE_W-1:0] h1;
		logic [uicf_pkg::BYTE_W-1:0] t;
		n_tok = $urandom_range(12, 1);
		repeat (n_tok) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				push_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
			end else if (kind < 52) begin
				sel = $urandom_range(3);
				case (sel)
					0: begin
						h0 = uicf_pkg::B_E2;
						h1 = uicf_pkg::B_80;
						t  = 8'($urandom_range(uicf_pkg::B_8F, uicf_pkg::B_8B));
					end
					1: begin
						h0 = uicf_pkg::B_E2;
						h1 = uicf_pkg::B_80;
						t  = 8'($urandom_range(uicf_pkg::B_AE, uicf_pkg::B_AA));
					end
					2: begin
						h0 = uicf_pkg::B_E2;
						h1 = uicf_pkg::B_81;
						t  = 8'($urandom_range(uicf_pkg::B_A9, uicf_pkg::B_A6));
					end
					default: begin
						h0 = uicf_pkg::B_EF;
						h1 = uicf_pkg::B_BB;
						t  = uicf_pkg::B_BF;
					end
				endcase
				push_byte(h0, 1'b0);
				push_byte(h1, 1'b0);
				push_byte(t, 1'b0);
			end else if (kind < 64) begin
				// prefix that may break off after one, two or three bytes
				h0 = $urandom_range(1) ? uicf_pkg::B_E2 : uicf_pkg::B_EF;
				push_byte(h0, 1'b0);
				sel = $urandom_range(2);
				if (sel >= 1) begin
					if ($urandom_range(3) == 0)
						h1 = 8'($urandom_range(255));
					else if (h0 == uicf_pkg::B_E2)
						h1 = $urandom_range(1) ? uicf_pkg::B_80 : uicf_pkg::B_81;
					else
						h1 = uicf_pkg::B_BB;
					push_byte(h1, 1'b0);
				end
				if (sel == 2) begin
					if ($urandom_range(1)) begin
						t = 8'($urandom_range(255));
					end else begin
						case ($urandom_range(7))
							0: t = 8'h8A;
							1: t = 8'h90;
							2: t = 8'hA9;
							3: t = 8'hAF;
							4: t = 8'hA5;
							5: t = 8'hAA;
							6: t = 8'hBE;
							default: t = 8'hC0;
						endcase
					end
					push_byte(t, 1'b0);
				end
			end else if (kind < 74) begin
				if ($urandom_range(3) == 0)
					push_byte(uicf_pkg::B_DEL, 1'b0);
				else
					push_byte(8'($urandom_range(8'h1F, 8'h01)), 1'b0);
			end else if (kind < 92) begin
				push_byte(8'($urandom_range(255, 1)), 1'b0);
			end else if (kind < 95) begin
				push_byte(uicf_pkg::B_NUL, 1'b0);
			end else begin
				push_byte(8'($urandom_range(255, 128)), 1'b0);
			end
		end
		pending_bytes[pending_bytes.size() - 1].last = 1'b1;
	endtask

	task automatic run_phase(input logic [uicf_pkg::LEN_W-1:0] lim, input int send_pct,
	                         input int stall_pct, input int n_items, input bit long_hold);
		int start;
		start = stim_pushed;
		write_max_length(lim);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		if (long_hold)
			hold_reqs++;
		while (stim_pushed - start < n_items)
			add_random_string();
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_max_length(uicf_pkg::MAX_LEN_RESET);
		// control bytes, tab, newline, DEL and the byte extremes
		push_byte(8'h01, 1'b0); push_byte(uicf_pkg::B_TAB, 1'b0);
		push_byte(uicf_pkg::B_LF, 1'b0); push_byte(8'h1F, 1'b0);
		push_byte(uicf_pkg::B_SPACE, 1'b0); push_byte(8'h7E, 1'b0);
		push_byte(uicf_pkg::B_DEL, 1'b0); push_byte(8'hFF, 1'b1);
		// one invisible sequence for each lead pair E2 80, E2 81 and EF BB
		push_byte(uicf_pkg::B_E2, 1'b0); push_byte(uicf_pkg::B_80, 1'b0);
		push_byte(uicf_pkg::B_8B, 1'b0);
		push_byte(uicf_pkg::B_E2, 1'b0); push_byte(uicf_pkg::B_81, 1'b0);
		push_byte(uicf_pkg::B_A9, 1'b0);
		push_byte(uicf_pkg::B_EF, 1'b0); push_byte(uicf_pkg::B_BB, 1'b0);
		push_byte(uicf_pkg::B_BF, 1'b0);
		push_byte(8'h41, 1'b1);
		// broken prefixes, then last while a prefix is held
		push_byte(uicf_pkg::B_E2, 1'b0); push_byte(uicf_pkg::B_E2, 1'b0);
		push_byte(uicf_pkg::B_80, 1'b0);
		push_byte(8'h41, 1'b0); push_byte(uicf_pkg::B_EF, 1'b1);
		// zero byte with a held prefix, later bytes ignored
		push_byte(8'h41, 1'b0); push_byte(uicf_pkg::B_E2, 1'b0);
		push_byte(uicf_pkg::B_NUL, 1'b0);
		push_byte(8'h42, 1'b0); push_byte(uicf_pkg::B_E2, 1'b1);
		// zero byte carrying last
		push_byte(uicf_pkg::B_NUL, 1'b1);
		wait_idle();

		run_phase(16'd0, 0, 0, 30, 1'b0);
		run_phase(16'd5, 69, 0, 50, 1'b0);
		run_phase(uicf_pkg::MAX_LEN_RESET, 0, 69, 50, 1'b0);
		run_phase(16'd1, 17, 17, 40, 1'b0);
		run_phase(16'd3, 0, 0, 45, 1'b1);
		run_phase(uicf_pkg::MAX_LEN_RESET, 17, 17, 40, 1'b0);

		if (expected_results.size() != 0)
			report_mismatch("results never delivered", 0, expected_results.size());
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
